// ===== hdl/mcs51_instruction_subset_exec_defines.svh =====
// Assertion macros used by the top level of the 8051 subset executor.
`ifndef MCS51_INSTRUCTION_SUBSET_EXEC_DEFINES_SVH
`define MCS51_INSTRUCTION_SUBSET_EXEC_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define MCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mcs51x assertion failed");
// Next-cycle implication, checked outside reset.
`define MCS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mcs51x assertion failed");
`else
`define MCS_ASSERT_IMP(lbl, ante, cons)
`define MCS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/mcs51x_pkg.sv =====
// Package with types, opcodes, addresses and class codes of the 8051 subset executor.
package mcs51x_pkg;

    // Internal RAM geometry; every RAM address is reduced to these bits.
    localparam int RAM_DEPTH = 256;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    typedef logic [RAM_AW-1:0] t_addr;

    // Channel payloads.
    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] operand_first;
        logic [7:0] operand_second;
    } t_in_item;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [7:0]  accumulator;
        logic [7:0]  status_word;
        logic        unknown_opcode;
    } t_out_item;

    // Instruction classes assigned by the front end.
    localparam logic [3:0] CL_NOP   = 4'd0;
    localparam logic [3:0] CL_AJMP  = 4'd1;
    localparam logic [3:0] CL_LJMP  = 4'd2;
    localparam logic [3:0] CL_LCALL = 4'd3;
    localparam logic [3:0] CL_RET   = 4'd4;
    localparam logic [3:0] CL_RR    = 4'd5;
    localparam logic [3:0] CL_RL    = 4'd6;
    localparam logic [3:0] CL_RRC   = 4'd7;
    localparam logic [3:0] CL_INCA  = 4'd8;
    localparam logic [3:0] CL_DPTR  = 4'd9;
    localparam logic [3:0] CL_DIR   = 4'd10;
    localparam logic [3:0] CL_IND   = 4'd11;
    localparam logic [3:0] CL_REG   = 4'd12;
    localparam logic [3:0] CL_JB    = 4'd13;
    localparam logic [3:0] CL_BAD   = 4'd14;

    // Queue entry between front and back.
    typedef struct packed {
        t_in_item   item;
        logic [3:0] cls;
    } t_q_entry;

    // Back end status seen by the top level.
    typedef struct packed {
        logic pop;
        logic busy;
        logic fin;
    } t_bk_stat;

    // Opcodes.
    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_LJMP     = 8'h02;
    localparam logic [7:0] OP_RR       = 8'h03;
    localparam logic [7:0] OP_JBC      = 8'h10;
    localparam logic [7:0] OP_LCALL    = 8'h12;
    localparam logic [7:0] OP_RRC      = 8'h13;
    localparam logic [7:0] OP_JB       = 8'h20;
    localparam logic [7:0] OP_RET      = 8'h22;
    localparam logic [7:0] OP_RL       = 8'h23;
    localparam logic [7:0] OP_INC_DPTR = 8'hA3;
    localparam logic [7:0] OP_INC_LO   = 8'h04;
    localparam logic [7:0] OP_INC_HI   = 8'h0F;
    localparam logic [7:0] OP_DEC_LO   = 8'h14;
    localparam logic [7:0] OP_DEC_HI   = 8'h1F;
    localparam logic [4:0] OP_AJMP_LOW = 5'h01;
    localparam logic [3:0] SUB_ACC     = 4'h4;
    localparam logic [3:0] SUB_DIR     = 4'h5;
    localparam logic [3:0] SUB_IND_HI  = 4'h7;

    // Special function register addresses and reset values.
    localparam logic [7:0] ADDR_ACC = 8'hE0;
    localparam logic [7:0] ADDR_PSW = 8'hD0;
    localparam logic [7:0] ADDR_SP  = 8'h81;
    localparam logic [7:0] ADDR_DPL = 8'h82;
    localparam logic [7:0] ADDR_DPH = 8'h83;
    localparam logic [7:0] BIT_BASE = 8'h20;
    localparam logic [7:0] SP_RESET = 8'h07;

    // Reduce a byte address to a RAM address.
    function automatic t_addr to_addr(input logic [7:0] a);
        return t_addr'(a);
    endfunction

endpackage

// ===== hdl/mcs51x_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcs51x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mcs51x_front.sv =====
// Front end: accepts instruction items and classifies the opcode.
module mcs51x_front
    import mcs51x_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in,
    input  logic     i_q_full,
    output logic     o_push,
    output t_q_entry o_push_data
);

    logic [7:0] op;
    logic [3:0] cls;

    assign op = i_in.opcode;

    // Opcode decode into execution classes.
    always_comb begin
        cls = CL_BAD;
        if (op[4:0] == OP_AJMP_LOW) begin
            cls = CL_AJMP;
        end else if ((op >= OP_INC_LO && op <= OP_INC_HI) ||
                     (op >= OP_DEC_LO && op <= OP_DEC_HI)) begin
            if (op[3:0] == SUB_ACC) begin
                cls = CL_INCA;
            end else if (op[3:0] == SUB_DIR) begin
                cls = CL_DIR;
            end else if (op[3:0] <= SUB_IND_HI) begin
                cls = CL_IND;
            end else begin
                cls = CL_REG;
            end
        end else begin
            case (op)
                OP_NOP:      cls = CL_NOP;
                OP_LJMP:     cls = CL_LJMP;
                OP_LCALL:    cls = CL_LCALL;
                OP_RET:      cls = CL_RET;
                OP_RR:       cls = CL_RR;
                OP_RL:       cls = CL_RL;
                OP_RRC:      cls = CL_RRC;
                OP_INC_DPTR: cls = CL_DPTR;
                OP_JB:       cls = CL_JB;
                OP_JBC:      cls = CL_JB;
                default:     cls = CL_BAD;
            endcase
        end
    end

    // The queue's fill level alone throttles the input.
    assign o_in_stall       = i_q_full;
    assign o_push           = i_in_valid && !i_q_full;
    assign o_push_data.item = i_in;
    assign o_push_data.cls  = cls;

endmodule

// ===== hdl/mcs51x_queue.sv =====
// Two-entry queue between the front and back ends.
module mcs51x_queue
    import mcs51x_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_data,
    output logic     o_full,
    output logic     o_valid,
    output t_q_entry o_data,
    input  logic     i_pop
);

    t_q_entry   r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

// ===== hdl/mcs51x_back.sv =====
// Back end: executes classified instructions against the PC, SFR copies and internal RAM.
module mcs51x_back
    import mcs51x_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_q_entry  i_head,
    output t_bk_stat  o_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam logic [2:0] S_DISP  = 3'd0;
    localparam logic [2:0] S_WB    = 3'd1;
    localparam logic [2:0] S_PTR   = 3'd2;
    localparam logic [2:0] S_CALL2 = 3'd3;
    localparam logic [2:0] S_RET2  = 3'd4;
    localparam logic [2:0] S_RET3  = 3'd5;
    localparam logic [2:0] S_JB    = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_acc, n_acc;
    logic [7:0]  r_psw, n_psw;
    logic [7:0]  r_sp, n_sp;
    logic [7:0]  r_dpl, n_dpl;
    logic [7:0]  r_dph, n_dph;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_b1, n_b1;
    logic [7:0]  r_b2, n_b2;
    t_addr       r_addr, n_addr;
    logic [7:0]  r_tmp, n_tmp;
    logic        r_sh_hit;
    logic [7:0]  r_sh_val;
    logic        r_rv;
    logic [RAM_DEPTH-1:0] r_vld;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;

    logic        out_free;
    logic [7:0]  rd_data;
    logic [7:0]  ram_q;
    logic        rd_en;
    t_addr       rd_addr;
    logic        sh_hit;
    logic [7:0]  sh_val;
    logic        wr_en;
    t_addr       wr_addr;
    logic [7:0]  wr_data;
    logic        wr_hit;
    logic        ram_we;
    logic        pop;
    logic        fin;
    logic        unk;
    logic [7:0]  op;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] ret_pc;
    logic [15:0] jb_next;
    logic [15:0] ajmp_base;
    logic [7:0]  sp_inc;
    logic [15:0] dptr_inc;
    logic [7:0]  step_data;
    logic        bit_set;

    assign op       = i_head.item.opcode;
    assign b1       = i_head.item.operand_first;
    assign b2       = i_head.item.operand_second;
    assign out_free = !r_ov || !i_out_stall;
    assign rd_data  = r_sh_hit ? r_sh_val : (r_rv ? ram_q : 8'h00);
    assign ret_pc   = r_pc + 16'd3;
    assign jb_next  = r_pc + 16'd3;
    assign ajmp_base = r_pc + 16'd2;
    assign sp_inc   = r_sp + 8'd1;
    assign dptr_inc = {r_dph, r_dpl} + 16'd1;
    assign step_data = r_op[4] ? (rd_data - 8'd1) : (rd_data + 8'd1);
    assign bit_set  = rd_data[r_b1[2:0]];

    // Read address against the SFR copies, sampled at issue.
    always_comb begin
        sh_hit = 1'b1;
        sh_val = r_acc;
        if (rd_addr == to_addr(ADDR_ACC)) begin
            sh_val = r_acc;
        end else if (rd_addr == to_addr(ADDR_PSW)) begin
            sh_val = r_psw;
        end else if (rd_addr == to_addr(ADDR_SP)) begin
            sh_val = r_sp;
        end else if (rd_addr == to_addr(ADDR_DPL)) begin
            sh_val = r_dpl;
        end else if (rd_addr == to_addr(ADDR_DPH)) begin
            sh_val = r_dph;
        end else begin
            sh_hit = 1'b0;
        end
    end

    // Sequencer and next-state logic.
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_acc   = r_acc;
        n_psw   = r_psw;
        n_sp    = r_sp;
        n_dpl   = r_dpl;
        n_dph   = r_dph;
        n_op    = r_op;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_addr  = r_addr;
        n_tmp   = r_tmp;
        rd_en   = 1'b0;
        rd_addr = r_addr;
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = 8'h00;
        wr_hit  = 1'b0;
        pop     = 1'b0;
        fin     = 1'b0;
        unk     = 1'b0;

        case (r_state)
            S_DISP: begin
                if (i_head_valid) begin
                    case (i_head.cls)
                        CL_DIR, CL_REG, CL_IND, CL_JB, CL_LCALL, CL_RET: begin
                            pop  = 1'b1;
                            n_op = op;
                            n_b1 = b1;
                            n_b2 = b2;
                        end
                        default: begin
                            pop = out_free;
                            fin = out_free;
                        end
                    endcase
                    // Items that finish at dispatch change state only when their result can be taken.
                    if (pop) begin
                        case (i_head.cls)
                            CL_NOP: n_pc = r_pc + 16'd1;
                            CL_AJMP: begin
                                n_pc = {ajmp_base[15:11], op[7:5], b1};
                            end
                            CL_LJMP: n_pc = {b1, b2};
                            CL_RR: begin
                                n_acc = {r_acc[0], r_acc[7:1]};
                                n_pc  = r_pc + 16'd1;
                            end
                            CL_RL: begin
                                n_acc = {r_acc[6:0], r_acc[7]};
                                n_pc  = r_pc + 16'd1;
                            end
                            CL_RRC: begin
                                n_acc = {r_psw[7], r_acc[7:1]};
                                n_psw = {r_acc[0], r_psw[6:0]};
                                n_pc  = r_pc + 16'd1;
                            end
                            CL_INCA: begin
                                n_acc = op[4] ? (r_acc - 8'd1) : (r_acc + 8'd1);
                                n_pc  = r_pc + 16'd1;
                            end
                            CL_DPTR: begin
                                {n_dph, n_dpl} = dptr_inc;
                                n_pc = r_pc + 16'd1;
                            end
                            CL_DIR: begin
                                rd_en   = 1'b1;
                                rd_addr = to_addr(b1);
                                n_addr  = to_addr(b1);
                                n_state = S_WB;
                            end
                            CL_REG: begin
                                rd_en   = 1'b1;
                                rd_addr = to_addr({3'b000, r_psw[4:3], op[2:0]});
                                n_addr  = rd_addr;
                                n_state = S_WB;
                            end
                            CL_IND: begin
                                rd_en   = 1'b1;
                                rd_addr = to_addr({3'b000, r_psw[4:3], 2'b00, op[0]});
                                n_state = S_PTR;
                            end
                            CL_JB: begin
                                rd_en   = 1'b1;
                                rd_addr = to_addr(BIT_BASE + {3'b000, b1[7:3]});
                                n_addr  = rd_addr;
                                n_state = S_JB;
                            end
                            CL_LCALL: begin
                                // Push the low byte of the return address.
                                n_sp    = sp_inc;
                                wr_en   = 1'b1;
                                wr_addr = to_addr(sp_inc);
                                wr_data = ret_pc[7:0];
                                n_state = S_CALL2;
                            end
                            CL_RET: begin
                                // Pop the high byte of the return address.
                                rd_en   = 1'b1;
                                rd_addr = to_addr(r_sp);
                                n_sp    = r_sp - 8'd1;
                                n_state = S_RET2;
                            end
                            default: unk = 1'b1;
                        endcase
                    end
                end
            end
            S_PTR: begin
                rd_en   = 1'b1;
                rd_addr = to_addr(rd_data);
                n_addr  = to_addr(rd_data);
                n_state = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    wr_en   = 1'b1;
                    wr_addr = r_addr;
                    wr_data = step_data;
                    n_pc    = r_pc + ((r_op[3:0] == SUB_DIR) ? 16'd2 : 16'd1);
                    fin     = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_JB: begin
                if (out_free) begin
                    if (bit_set) begin
                        if (r_op == OP_JBC) begin
                            wr_en   = 1'b1;
                            wr_addr = r_addr;
                            wr_data = rd_data & ~(8'h01 << r_b1[2:0]);
                        end
                        n_pc = jb_next + {{8{r_b2[7]}}, r_b2};
                    end else begin
                        n_pc = jb_next;
                    end
                    fin     = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_CALL2: begin
                if (out_free) begin
                    n_sp    = sp_inc;
                    wr_en   = 1'b1;
                    wr_addr = to_addr(sp_inc);
                    wr_data = ret_pc[15:8];
                    n_pc    = {r_b1, r_b2};
                    fin     = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_RET2: begin
                n_tmp   = rd_data;
                rd_en   = 1'b1;
                rd_addr = to_addr(r_sp);
                n_sp    = r_sp - 8'd1;
                n_state = S_RET3;
            end
            S_RET3: begin
                if (out_free) begin
                    n_pc    = {r_tmp, rd_data};
                    fin     = 1'b1;
                    n_state = S_DISP;
                end
            end
            default: n_state = S_DISP;
        endcase

        // A write to an SFR address lands in its copy and overrides earlier next-state values.
        if (wr_en) begin
            wr_hit = 1'b1;
            if (wr_addr == to_addr(ADDR_ACC)) begin
                n_acc = wr_data;
            end else if (wr_addr == to_addr(ADDR_PSW)) begin
                n_psw = wr_data;
            end else if (wr_addr == to_addr(ADDR_SP)) begin
                n_sp = wr_data;
            end else if (wr_addr == to_addr(ADDR_DPL)) begin
                n_dpl = wr_data;
            end else if (wr_addr == to_addr(ADDR_DPH)) begin
                n_dph = wr_data;
            end else begin
                wr_hit = 1'b0;
            end
        end

        // Result register: loaded on completion, freed when taken.
        n_ov  = r_ov;
        n_out = r_out;
        if (fin) begin
            n_ov  = 1'b1;
            n_out = '{next_pc: unk ? r_pc : n_pc, accumulator: n_acc,
                      status_word: n_psw, unknown_opcode: unk};
        end else if (!i_out_stall) begin
            n_ov = 1'b0;
        end
    end

    assign ram_we = wr_en && !wr_hit;

    // Architectural and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DISP;
            r_pc    <= 16'h0000;
            r_acc   <= 8'h00;
            r_psw   <= 8'h00;
            r_sp    <= SP_RESET;
            r_dpl   <= 8'h00;
            r_dph   <= 8'h00;
            r_vld   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_acc   <= n_acc;
            r_psw   <= n_psw;
            r_sp    <= n_sp;
            r_dpl   <= n_dpl;
            r_dph   <= n_dph;
            r_ov    <= n_ov;
            if (ram_we) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Operand and read-side payload registers.
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_b1   <= n_b1;
        r_b2   <= n_b2;
        r_addr <= n_addr;
        r_tmp  <= n_tmp;
        r_out  <= n_out;
        if (rd_en) begin
            r_sh_hit <= sh_hit;
            r_sh_val <= sh_val;
            r_rv     <= r_vld[rd_addr];
        end
    end

    mcs51x_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign o_stat.pop  = pop;
    assign o_stat.busy = (r_state != S_DISP);
    assign o_stat.fin  = fin;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

// ===== hdl/mcs51_instruction_subset_exec.sv =====
// Top level of the 8051 instruction-subset executor.
// Each input item is one fetched instruction and yields one result item with the new PC,
// ACC, PSW and an unknown-opcode flag. NOP, AJMP, LJMP, RR, RL, RRC, INC/DEC A, INC DPTR and
// unknown opcodes finish at dispatch; INC/DEC direct or Rn, JB/JBC and LCALL pass through
// write-back, bit-test or second-push state; INC/DEC @Ri read a pointer and RET pops
// in two reads, as the single synchronous RAM has registered read data. ACC, PSW, SP, DPL
// and DPH live in registers, and RAM entries read as zero until first written, so no
// clearing pass follows reset. A two-entry queue lets new items be taken while one executes.
`include "mcs51_instruction_subset_exec_defines.svh"
module mcs51_instruction_subset_exec
    import mcs51x_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic     w_push;
    t_q_entry w_push_data;
    logic     w_q_full;
    logic     w_q_valid;
    t_q_entry w_q_head;
    t_bk_stat w_bk;

    mcs51x_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    mcs51x_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_head),
        .i_pop   (w_bk.pop)
    );

    mcs51x_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_q_valid),
        .i_head       (w_q_head),
        .o_stat       (w_bk),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

    // A full queue is never empty, and the back end pops only an existing entry.
    `MCS_ASSERT_IMP(a_stall_has_entry, o_in_stall, w_q_valid)
    `MCS_ASSERT_IMP(a_pop_when_idle, w_bk.pop, !w_bk.busy && w_q_valid)
    // A completed instruction shows its result on the next cycle.
    `MCS_ASSERT_NXT(a_fin_shows_result, w_bk.fin, o_out_valid)

endmodule

// ===== verif/mcs51_instruction_subset_exec_test.sv =====
// Self-checking testbench of the 8051 instruction-subset executor.
module mcs51_instruction_subset_exec_test;
    import mcs51x_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1250;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    mcs51_instruction_subset_exec dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: program counter and internal RAM.
    logic [15:0] model_pc;
    logic [7:0]  model_ram [RAM_DEPTH];
    t_out_item   pending_results [$];
    int          mismatches = 0;
    int          watchdog = 0;
    bit          quiet_phase = 0;
    bit          stim_done = 0;

    // Directed items with a typed-in result where it is obvious.
    typedef struct {
        t_in_item  item;
        bit        known;
        t_out_item result;
    } t_row;

    function automatic logic [7:0] rd(input logic [7:0] a);
        return model_ram[to_addr(a)];
    endfunction

    function automatic void wr(input logic [7:0] a, input logic [7:0] v);
        model_ram[to_addr(a)] = v;
    endfunction

    function automatic logic [7:0] bank_reg(input logic [2:0] n);
        logic [7:0] psw;
        psw = rd(ADDR_PSW);
        return {3'b000, psw[4:3], n};
    endfunction

    // Execute one instruction in the predictor and return its result item.
    function automatic t_out_item execute(input t_in_item it);
        t_out_item   r;
        logic [7:0]  op, a, v, acc, psw, sp, hi, lo, msk;
        logic [15:0] pc, dptr;
        bit          bad;
        op = it.opcode;
        pc = model_pc;
        bad = 0;
        if (op[4:0] == OP_AJMP_LOW) begin
            pc = pc + 16'd2;
            pc = {pc[15:11], op[7:5], it.operand_first};
        end else if ((op >= OP_INC_LO && op <= OP_INC_HI) ||
                     (op >= OP_DEC_LO && op <= OP_DEC_HI)) begin
            if (op[3:0] == SUB_ACC) a = ADDR_ACC;
            else if (op[3:0] == SUB_DIR) a = it.operand_first;
            else if (op[3:0] <= SUB_IND_HI) a = rd(bank_reg({2'b00, op[0]}));
            else a = bank_reg(op[2:0]);
            pc = pc + ((op[3:0] == SUB_DIR) ? 16'd2 : 16'd1);
            wr(a, op[4] ? rd(a) - 8'd1 : rd(a) + 8'd1);
        end else begin
            acc = rd(ADDR_ACC);
            case (op)
                OP_NOP: pc = pc + 16'd1;
                OP_LJMP: pc = {it.operand_first, it.operand_second};
                OP_LCALL: begin
                    dptr = pc + 16'd3;
                    sp = rd(ADDR_SP) + 8'd1; wr(ADDR_SP, sp); wr(sp, dptr[7:0]);
                    sp = rd(ADDR_SP) + 8'd1; wr(ADDR_SP, sp); wr(sp, dptr[15:8]);
                    pc = {it.operand_first, it.operand_second};
                end
                OP_RET: begin
                    sp = rd(ADDR_SP); hi = rd(sp); wr(ADDR_SP, sp - 8'd1);
                    sp = rd(ADDR_SP); lo = rd(sp); wr(ADDR_SP, sp - 8'd1);
                    pc = {hi, lo};
                end
                OP_RR: begin wr(ADDR_ACC, {acc[0], acc[7:1]}); pc = pc + 16'd1; end
                OP_RL: begin wr(ADDR_ACC, {acc[6:0], acc[7]}); pc = pc + 16'd1; end
                OP_RRC: begin
                    psw = rd(ADDR_PSW);
                    wr(ADDR_ACC, {psw[7], acc[7:1]});
                    wr(ADDR_PSW, {acc[0], psw[6:0]});
                    pc = pc + 16'd1;
                end
                OP_INC_DPTR: begin
                    dptr = {rd(ADDR_DPH), rd(ADDR_DPL)} + 16'd1;
                    wr(ADDR_DPL, dptr[7:0]);
                    wr(ADDR_DPH, dptr[15:8]);
                    pc = pc + 16'd1;
                end
                OP_JB, OP_JBC: begin
                    a = BIT_BASE + {3'b000, it.operand_first[7:3]};
                    msk = 8'd1 << it.operand_first[2:0];
                    v = rd(a);
                    pc = pc + 16'd3;
                    if ((v & msk) != 0) begin
                        if (op == OP_JBC) wr(a, v & ~msk);
                        pc = pc + {{8{it.operand_second[7]}}, it.operand_second};
                    end
                end
                default: bad = 1;
            endcase
        end
        model_pc = pc;
        r.next_pc = model_pc;
        r.accumulator = rd(ADDR_ACC);
        r.status_word = rd(ADDR_PSW);
        r.unknown_opcode = bad;
        return r;
    endfunction

    function automatic t_in_item mk(input logic [7:0] o, input logic [7:0] f,
                                    input logic [7:0] s);
        t_in_item it;
        it.opcode = o; it.operand_first = f; it.operand_second = s;
        return it;
    endfunction

    // Random instruction, mostly supported opcodes with RAM-touching operands.
    function automatic t_in_item random_item();
        logic [7:0] ops [16];
        logic [7:0] op;
        int k;
        ops = '{OP_NOP, OP_LJMP, OP_RR, OP_JBC, OP_LCALL, OP_RRC, OP_JB, OP_RET,
                OP_RL, OP_INC_DPTR, 8'h05, 8'h15, 8'h06, 8'h17, 8'h0C, 8'h1B};
        k = $urandom_range(0, 99);
        if (k < 55) op = ops[$urandom_range(0, 15)];
        else if (k < 75) op = 8'($urandom_range(OP_INC_LO, OP_DEC_HI));
        else if (k < 85) op = {3'($urandom), OP_AJMP_LOW};
        else op = 8'($urandom);
        return mk(op, 8'($urandom), 8'($urandom));
    endfunction

    // Reset predictor.
    initial begin
        model_pc = '0;
        foreach (model_ram[i]) model_ram[i] = '0;
        model_ram[to_addr(ADDR_SP)] = SP_RESET;
    end

    // Sink side: random stall, check results at the rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %h", o_out);
            end else begin
                want = pending_results.pop_front();
                if (o_out.next_pc !== want.next_pc ||
                    o_out.accumulator !== want.accumulator ||
                    o_out.status_word !== want.status_word ||
                    o_out.unknown_opcode !== want.unknown_opcode) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pc %h acc %h psw %h unk %b, got %h %h %h %b",
                                 want.next_pc, want.accumulator, want.status_word,
                                 want.unknown_opcode, o_out.next_pc, o_out.accumulator,
                                 o_out.status_word, o_out.unknown_opcode);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 17);
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || !i_rst_n || (stim_done && pending_results.size() == 0))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("mcs51_instruction_subset_exec test failed");
            $finish;
        end
    end

    // Present one item and hold it until accepted; valid drops only while idling.
    task automatic send(input t_in_item it, input bit known, input t_out_item res);
        t_out_item got;
        while (!quiet_phase && $urandom_range(0, 99) < 17) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = execute(it);
        if (known && got != res) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with prediction for opcode %h", it.opcode);
        end
        pending_results.push_back(got);
        @(negedge i_clk);
    endtask

    initial begin
        t_row rows [$];
        t_row r;
        t_out_item none;
        none = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset values, extremes, every operation.
        r.known = 1; r.item = mk(OP_NOP, 8'h00, 8'h00);
        r.result = '{16'h0001, 8'h00, 8'h00, 1'b0}; rows.push_back(r);
        r.item = mk(8'hA5, 8'hFF, 8'hFF);
        r.result = '{16'h0001, 8'h00, 8'h00, 1'b1}; rows.push_back(r);
        r.item = mk(OP_DEC_LO, 8'h00, 8'h00);
        r.result = '{16'h0002, 8'hFF, 8'h00, 1'b0}; rows.push_back(r);
        r.item = mk(OP_INC_LO, 8'h00, 8'h00);
        r.result = '{16'h0003, 8'h00, 8'h00, 1'b0}; rows.push_back(r);
        r.item = mk(OP_LJMP, 8'hFF, 8'hFE);
        r.result = '{16'hFFFE, 8'h00, 8'h00, 1'b0}; rows.push_back(r);
        r.known = 0; r.result = none;
        r.item = mk(8'hE1, 8'hFF, 8'h00); rows.push_back(r);  // AJMP top page across wrap
        r.item = mk(8'h15, ADDR_ACC, 8'h00); rows.push_back(r);
        r.item = mk(OP_RRC, 8'h00, 8'h00); rows.push_back(r);
        r.item = mk(OP_RR, 8'h00, 8'h00); rows.push_back(r);
        r.item = mk(OP_RL, 8'h00, 8'h00); rows.push_back(r);
        r.item = mk(8'h05, ADDR_PSW, 8'h00); rows.push_back(r);
        r.item = mk(8'h05, ADDR_PSW, 8'h00); rows.push_back(r);
        r.item = mk(8'h0F, 8'h00, 8'h00); rows.push_back(r);
        r.item = mk(8'h06, 8'h00, 8'h00); rows.push_back(r);
        r.item = mk(8'h17, 8'h00, 8'h00); rows.push_back(r);
        r.item = mk(8'h15, ADDR_DPL, 8'h00); rows.push_back(r);
        r.item = mk(OP_INC_DPTR, 8'h00, 8'h00); rows.push_back(r);
        r.item = mk(8'h05, 8'h20, 8'h00); rows.push_back(r);
        r.item = mk(OP_JB, 8'h00, 8'h80); rows.push_back(r);   // taken, backward
        r.item = mk(OP_JBC, 8'h00, 8'h7F); rows.push_back(r);  // taken, clears bit
        r.item = mk(OP_JBC, 8'h00, 8'h7F); rows.push_back(r);  // not taken
        r.item = mk(OP_JB, 8'hFF, 8'h10); rows.push_back(r);
        r.item = mk(OP_LCALL, 8'h12, 8'h34); rows.push_back(r);
        r.item = mk(OP_RET, 8'h00, 8'h00); rows.push_back(r);
        r.item = mk(OP_RET, 8'h00, 8'h00); rows.push_back(r);  // second return, with no matching call
        foreach (rows[i]) send(rows[i].item, rows[i].known, rows[i].result);

        // Random items; the middle stretch runs with no idling.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_phase = (n >= 500 && n < 700);
            send(random_item(), 0, none);
        end
        i_in_valid <= 1'b0;
        quiet_phase = 0;
        stim_done = 1;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("mcs51_instruction_subset_exec test passed");
        else
            $display("mcs51_instruction_subset_exec test failed");
        $finish;
    end
endmodule

// ===== mcs51_instruction_subset_exec.f =====
+incdir+hdl
hdl/mcs51x_pkg.sv
hdl/mcs51x_ram.sv
hdl/mcs51x_front.sv
hdl/mcs51x_queue.sv
hdl/mcs51x_back.sv
hdl/mcs51_instruction_subset_exec.sv
verif/mcs51_instruction_subset_exec_test.sv
